// ===== hw/rtl/pllm_pkg.sv =====
// pllm_pkg: constants and types for the piecewise linear lookup mapper
// no dependencies

package pllm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam logic [8:0] TABLE_SIZE_RESET = 9'd2;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_MAP  = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_SCAN   = 7'b0000010,
        ST_FETCH  = 7'b0000100,
        ST_MUL    = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_FINISH = 7'b0100000,
        ST_OUT    = 7'b1000000
    } pllm_state_t;

endpackage

// ===== hw/rtl/piecewise_linear_lut_mapper.sv =====
// piecewise_linear_lut_mapper: top level, breakpoint memories, scan and divider
// depends on pllm_pkg

// Maps samples through a breakpoint table by piecewise linear interpolation.
// A load transaction writes one (x, y) breakpoint into the x and y memories
// and returns no result. A map transaction scans the breakpoints one per cycle
// through the single read port of the memories until the first x not below the
// sample (or the end of the table), then reads the stop entry again to pair it
// with the last entry below, forms the 64-bit product (s - x0) * |y1 - y0| from
// two 32x16 partial products and divides it by (x1 - x0) with a restoring
// divider at one quotient bit per cycle. A map that ends on the first or the
// last y skips the multiply and divide. The divider and the scan are the limits.
// Only one item is in work at a time; the result waits in an output register
// and the next input is taken the cycle after it is delivered. table_size is
// written over its own valid/ready port and is taken any time. Entries are
// undefined until loaded; maps must only touch loaded entries.

module piecewise_linear_lut_mapper
    import pllm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  point_index,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] mapped_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  table_size
);

    // breakpoint storage
    logic [31:0] mem_x [TABLE_DEPTH];
    logic [31:0] mem_y [TABLE_DEPTH];
    logic [31:0] rd_x_reg, rd_y_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;

    pllm_state_t state_reg, state_next;
    logic [8:0]  tsize_reg;
    logic [CNT_W-1:0] n_act;          // active entry count
    logic [CNT_W-1:0] idx_reg;        // entry whose data is in rd_*_reg
    logic        found_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] x0_reg, y0_reg;
    logic        second_reg;          // fetch phase for next pair
    logic [63:0] num_reg;
    logic [31:0] den_reg, magy_reg;
    logic        neg_reg;
    logic [32:0] rem_reg;
    logic [63:0] quo_reg;
    logic [6:0]  bit_cnt_reg;
    logic signed [31:0] res_reg;
    logic        out_valid_reg;
    logic [47:0] lo_prod_reg;
    logic [63:0] hi_prod_reg;
    logic        mul_ph_reg;

    logic in_acc, out_acc;
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign mapped_value = res_reg;
    assign cfg_ready = 1'b1;

    // clamp table size to 1..depth
    always_comb
    begin
        if (tsize_reg == 9'd0)
            n_act = CNT_W'(1);
        else if (int'(tsize_reg) > TABLE_DEPTH)
            n_act = CNT_W'(TABLE_DEPTH);
        else
            n_act = CNT_W'(tsize_reg);
    end

    // memory write and registered read
    always_ff @(posedge clk)
    begin
        if (in_acc && kind == KIND_LOAD)
        begin
            mem_x[point_index[IDX_W-1:0]] <= point_x;
            mem_y[point_index[IDX_W-1:0]] <= point_y;
        end
        if (rd_en)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    logic signed [31:0] cur_x, cur_y;
    assign cur_x = $signed(rd_x_reg);
    assign cur_y = $signed(rd_y_reg);
    logic cur_below;
    assign cur_below = s_reg > cur_x;

    logic signed [32:0] dy_w;
    assign dy_w = {cur_y[31], cur_y} - {y0_reg[31], y0_reg};

    always_comb
    begin
        state_next = state_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                rd_en = 1'b1;
                if (in_acc && kind == KIND_MAP)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                // rd regs hold entry idx_reg
                rd_en = 1'b1;
                rd_addr = idx_reg[IDX_W-1:0] + IDX_W'(1);
                if (!cur_below || idx_reg == n_act - CNT_W'(1))
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                // read the stop entry back as the upper point of the pair
                rd_en = 1'b1;
                rd_addr = idx_reg[IDX_W-1:0];
                if (!found_reg || idx_reg == n_act)
                    state_next = ST_OUT;
                else if (second_reg)
                    state_next = (cur_x <= x0_reg) ? ST_OUT : ST_MUL;
            end
            ST_MUL:    if (mul_ph_reg) state_next = ST_DIV;
            ST_DIV:    if (bit_cnt_reg == 7'd63) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    logic [32:0] trial;
    assign trial = {rem_reg[31:0], num_reg[63]} - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tsize_reg     <= TABLE_SIZE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                tsize_reg <= table_size;
            if (state_reg == ST_OUT)
                out_valid_reg <= 1'b1;
            else if (out_acc)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                s_reg      <= sample;
                idx_reg    <= '0;
                found_reg  <= 1'b0;
                second_reg <= 1'b0;
                mul_ph_reg <= 1'b0;
            end
            ST_SCAN:
            begin
                if (idx_reg == '0 && !cur_below)
                    res_reg <= cur_y;          // first y if nothing below
                if (cur_below)
                begin
                    found_reg <= 1'b1;
                    x0_reg <= cur_x;
                    y0_reg <= cur_y;
                    res_reg <= cur_y;
                    idx_reg <= idx_reg + CNT_W'(1);
                end
            end
            ST_FETCH:
            begin
                // data from addr idx_reg is in the rd regs once second_reg is set
                second_reg <= 1'b1;
                if (second_reg)
                begin
                    num_reg  <= 64'(($signed({s_reg[31], s_reg})
                                - $signed({x0_reg[31], x0_reg})));
                    den_reg  <= 32'({cur_x[31], cur_x} - {x0_reg[31], x0_reg});
                    neg_reg  <= dy_w[32];
                    magy_reg <= dy_w[32] ? 32'(-dy_w) : dy_w[31:0];
                end
            end
            ST_MUL:
            begin
                // two 32x16 halves: num fits 32 bits, |dy| up to 32 bits
                mul_ph_reg <= 1'b1;
                if (!mul_ph_reg)
                begin
                    lo_prod_reg <= 48'(num_reg[31:0] * magy_reg[15:0]);
                    hi_prod_reg <= 64'(num_reg[31:0] * magy_reg[31:16]);
                end
                else
                begin
                    num_reg <= (hi_prod_reg << 16) + 64'(lo_prod_reg);
                    rem_reg <= '0;
                    bit_cnt_reg <= '0;
                end
            end
            ST_DIV:
            begin
                bit_cnt_reg <= bit_cnt_reg + 7'd1;
                num_reg <= {num_reg[62:0], 1'b0};
                if (!trial[32] || rem_reg[31])
                begin
                    rem_reg <= {1'b0, trial[31:0]};
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= {rem_reg[31:0], num_reg[63]};
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
            end
            ST_FINISH:
                res_reg <= neg_reg ? y0_reg - quo_reg[31:0] : y0_reg + quo_reg[31:0];
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_no_out_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall) else $error("accepted input with pending result");
    a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> bit_cnt_reg <= 7'd63) else $error("divider overran");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> idx_reg < n_act) else $error("scan past table");
`endif

endmodule
